@@ rtl/bsm_pkg.sv @@
// ----------------------------------------------------------------------------
// bsm_pkg
// Shared types and codes for the byte stack machine core.
// ----------------------------------------------------------------------------
package bsm_pkg;

  localparam int ADDR_BITS = 16;

  typedef logic [ADDR_BITS-1:0] addr_t;

  // request op codes
  localparam logic [1:0] OP_STEP    = 2'd0;
  localparam logic [1:0] OP_WRITE   = 2'd1;
  localparam logic [1:0] OP_READ    = 2'd2;
  localparam logic [1:0] OP_RESTART = 2'd3;

  // instruction opcodes
  localparam logic [7:0] OPC_HALT  = 8'h00;
  localparam logic [7:0] OPC_ADD   = 8'h10;
  localparam logic [7:0] OPC_SUB   = 8'h11;
  localparam logic [7:0] OPC_AND   = 8'h12;
  localparam logic [7:0] OPC_OR    = 8'h13;
  localparam logic [7:0] OPC_XOR   = 8'h14;
  localparam logic [7:0] OPC_DROP  = 8'h20;
  localparam logic [7:0] OPC_DUP   = 8'h21;
  localparam logic [7:0] OPC_OVER  = 8'h22;
  localparam logic [7:0] OPC_SWAP  = 8'h23;
  localparam logic [7:0] OPC_STORE = 8'h30;
  localparam logic [7:0] OPC_FETCH = 8'h31;
  localparam logic [7:0] OPC_LIT   = 8'h40;
  localparam logic [7:0] OPC_IF    = 8'h50;
  localparam logic [7:0] OPC_CALL  = 8'h60;
  localparam logic [7:0] OPC_EXIT  = 8'h61;

  // config register select (paddr bit 2)
  localparam logic REG_START_ADDRESS = 1'b0;
  localparam logic REG_STACK_START   = 1'b1;

  typedef struct packed {
    logic [7:0] opc;
    logic [7:0] a;
    logic [7:0] b;
  } alu_req_t;

endpackage

@@ rtl/bsm_ram.sv @@
// ----------------------------------------------------------------------------
// bsm_ram
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module bsm_ram #(
  parameter int AW = 16,
  parameter int DW = 8
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic          re_i,
  input  logic [AW-1:0] addr_i,
  input  logic [DW-1:0] wdata_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/bsm_alu.sv @@
// ----------------------------------------------------------------------------
// bsm_alu
// Byte arithmetic and logic unit for the add, sub, and, or and xor opcodes.
// ----------------------------------------------------------------------------
module bsm_alu (
  input  bsm_pkg::alu_req_t req_i,
  output logic [7:0]        res_o
);

  always_comb begin
    case (req_i.opc)
      bsm_pkg::OPC_ADD: res_o = req_i.a + req_i.b;
      bsm_pkg::OPC_SUB: res_o = req_i.a - req_i.b;
      bsm_pkg::OPC_AND: res_o = req_i.a & req_i.b;
      bsm_pkg::OPC_OR:  res_o = req_i.a | req_i.b;
      bsm_pkg::OPC_XOR: res_o = req_i.a ^ req_i.b;
      default:          res_o = '0;
    endcase
  end

endmodule

@@ rtl/byte_stack_machine_core.sv @@
// ----------------------------------------------------------------------------
// byte_stack_machine_core
// 8-bit stack processor over one byte RAM holding program, data and stack.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+-----------------------------------------
//   in       | in_valid_i/in_stall_o | op_i, address_i, data_i
//   out      | out_valid_o/out_stall_i| read_data_o .. steps_taken_o
//   config   | APB psel/penable      | start_address, stack_start
//
// Memory write, read and restart go from idle to the output state; a step
// walks more states, call the most, one single-port RAM access per cycle.
// Only in the idle state is a request taken; a finished result waits in the
// output register so the next request can be taken meanwhile.
// Reset initialises control state; RAM contents are undefined until written.
// ----------------------------------------------------------------------------
module byte_stack_machine_core (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic [15:0] address_i,
  input  logic [7:0]  data_i,

  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  read_data_o,
  output logic [15:0] program_counter_out_o,
  output logic [15:0] stack_pointer_out_o,
  output logic [7:0]  opcode_done_o,
  output logic        halted_o,
  output logic        bad_opcode_o,
  output logic [31:0] steps_taken_o,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = bsm_pkg::ADDR_BITS;

  localparam logic [4:0] ST_IDLE     = 5'd0;
  localparam logic [4:0] ST_DECODE   = 5'd1;
  localparam logic [4:0] ST_POP1     = 5'd2;
  localparam logic [4:0] ST_POP2     = 5'd3;
  localparam logic [4:0] ST_POP3     = 5'd4;
  localparam logic [4:0] ST_WR_ALU   = 5'd5;
  localparam logic [4:0] ST_WR_STORE = 5'd6;
  localparam logic [4:0] ST_RD_AB    = 5'd7;
  localparam logic [4:0] ST_RD_PUSH  = 5'd8;
  localparam logic [4:0] ST_PUSH     = 5'd9;
  localparam logic [4:0] ST_SWAP_RD  = 5'd10;
  localparam logic [4:0] ST_SWAP_V   = 5'd11;
  localparam logic [4:0] ST_SWAP_WR2 = 5'd12;
  localparam logic [4:0] ST_SWAP_WR1 = 5'd13;
  localparam logic [4:0] ST_IF_CHK   = 5'd14;
  localparam logic [4:0] ST_CALL_LO  = 5'd15;
  localparam logic [4:0] ST_CALL_HI  = 5'd16;
  localparam logic [4:0] ST_CALL_RD  = 5'd17;
  localparam logic [4:0] ST_JMP_HI   = 5'd18;
  localparam logic [4:0] ST_JMP_LO   = 5'd19;
  localparam logic [4:0] ST_OUT      = 5'd20;

  function automatic bsm_pkg::addr_t pair(logic [7:0] hi, logic [7:0] lo);
    return bsm_pkg::addr_t'({hi, lo});
  endfunction

  logic [4:0]     state_q, state_d;
  bsm_pkg::addr_t pc_q, pc_d, sp_q, sp_d;
  logic [7:0]     a_q, a_d, b_q, b_d, v_q, v_d, opc_q, opc_d;
  logic [1:0]     op_q, op_d;
  logic           stopped_q, stopped_d, invalid_q, invalid_d;
  logic [31:0]    steps_q, steps_d;
  logic [15:0]    start_q, stack_q;

  logic           in_acc, out_load;
  logic           out_valid_q;
  logic [7:0]     read_data_q, opcode_done_q;
  logic [15:0]    pc_out_q, sp_out_q;
  logic           halted_q, bad_q;
  logic [31:0]    steps_out_q;

  logic           ram_we, ram_re;
  bsm_pkg::addr_t ram_addr;
  logic [7:0]     ram_wdata, ram_rdata;

  bsm_pkg::alu_req_t alu_req;
  logic [7:0]        alu_res;

  bsm_pkg::addr_t sp_inc, sp_inc2, sp_dec, pc_inc, pc_inc2;
  logic [15:0]    ret16;

  assign sp_inc  = sp_q + bsm_pkg::addr_t'(1);
  assign sp_inc2 = sp_q + bsm_pkg::addr_t'(2);
  assign sp_dec  = sp_q - bsm_pkg::addr_t'(1);
  assign pc_inc  = pc_q + bsm_pkg::addr_t'(1);
  assign pc_inc2 = pc_q + bsm_pkg::addr_t'(2);
  assign ret16   = 16'(pc_inc2);

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_load   = (state_q == ST_OUT) && (!out_valid_q || !out_stall_i);

  assign alu_req.opc = opc_q;
  assign alu_req.a   = a_q;
  assign alu_req.b   = ram_rdata;

  bsm_alu u_alu (
    .req_i (alu_req),
    .res_o (alu_res)
  );

  bsm_ram #(
    .AW (AW),
    .DW (8)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d   = state_q;
    pc_d      = pc_q;
    sp_d      = sp_q;
    a_d       = a_q;
    b_d       = b_q;
    v_d       = v_q;
    opc_d     = opc_q;
    op_d      = op_q;
    stopped_d = stopped_q;
    invalid_d = invalid_q;
    steps_d   = steps_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_addr  = pc_q;
    ram_wdata = ram_rdata;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          op_d    = op_i;
          opc_d   = '0;
          state_d = ST_OUT;
          unique case (op_i)
            bsm_pkg::OP_STEP: begin
              if (!stopped_q) begin
                ram_re   = 1'b1;
                ram_addr = pc_q;
                pc_d     = pc_inc;
                state_d  = ST_DECODE;
              end
            end
            bsm_pkg::OP_WRITE: begin
              ram_we    = 1'b1;
              ram_addr  = address_i[AW-1:0];
              ram_wdata = data_i;
            end
            bsm_pkg::OP_READ: begin
              ram_re   = 1'b1;
              ram_addr = address_i[AW-1:0];
            end
            bsm_pkg::OP_RESTART: begin
              pc_d      = start_q[AW-1:0];
              sp_d      = stack_q[AW-1:0];
              stopped_d = 1'b0;
              invalid_d = 1'b0;
            end
          endcase
        end
      end
      ST_DECODE: begin
        opc_d   = ram_rdata;
        steps_d = steps_q + 32'd1;
        unique case (ram_rdata) inside
          bsm_pkg::OPC_HALT: begin
            stopped_d = 1'b1;
            state_d   = ST_OUT;
          end
          bsm_pkg::OPC_ADD, bsm_pkg::OPC_SUB, bsm_pkg::OPC_AND, bsm_pkg::OPC_OR,
          bsm_pkg::OPC_XOR, bsm_pkg::OPC_DROP, bsm_pkg::OPC_STORE,
          bsm_pkg::OPC_FETCH, bsm_pkg::OPC_IF, bsm_pkg::OPC_EXIT: begin
            state_d = ST_POP1;
          end
          bsm_pkg::OPC_DUP, bsm_pkg::OPC_OVER, bsm_pkg::OPC_LIT: begin
            state_d = ST_RD_PUSH;
          end
          bsm_pkg::OPC_SWAP: state_d = ST_SWAP_RD;
          bsm_pkg::OPC_CALL: state_d = ST_CALL_LO;
          default: begin
            stopped_d = 1'b1;
            invalid_d = 1'b1;
            state_d   = ST_OUT;
          end
        endcase
      end
      ST_POP1: begin
        ram_re   = 1'b1;
        ram_addr = sp_inc;
        sp_d     = sp_inc;
        case (opc_q)
          bsm_pkg::OPC_DROP: state_d = ST_OUT;
          bsm_pkg::OPC_IF:   state_d = ST_IF_CHK;
          default:           state_d = ST_POP2;
        endcase
      end
      ST_POP2: begin
        a_d      = ram_rdata;
        ram_re   = 1'b1;
        ram_addr = sp_inc;
        sp_d     = sp_inc;
        case (opc_q)
          bsm_pkg::OPC_STORE: state_d = ST_POP3;
          bsm_pkg::OPC_FETCH: state_d = ST_RD_AB;
          bsm_pkg::OPC_EXIT:  state_d = ST_JMP_LO;
          default:            state_d = ST_WR_ALU;
        endcase
      end
      ST_POP3: begin
        b_d      = ram_rdata;
        ram_re   = 1'b1;
        ram_addr = sp_inc;
        sp_d     = sp_inc;
        state_d  = ST_WR_STORE;
      end
      ST_WR_ALU: begin
        ram_we    = 1'b1;
        ram_addr  = sp_q;
        ram_wdata = alu_res;
        sp_d      = sp_dec;
        state_d   = ST_OUT;
      end
      ST_WR_STORE: begin
        ram_we    = 1'b1;
        ram_addr  = pair(a_q, b_q);
        ram_wdata = ram_rdata;
        state_d   = ST_OUT;
      end
      ST_RD_AB: begin
        ram_re   = 1'b1;
        ram_addr = pair(a_q, ram_rdata);
        state_d  = ST_PUSH;
      end
      ST_RD_PUSH: begin
        ram_re = 1'b1;
        case (opc_q)
          bsm_pkg::OPC_DUP:  ram_addr = sp_inc;
          bsm_pkg::OPC_OVER: ram_addr = sp_inc2;
          default: begin
            ram_addr = pc_q;
            pc_d     = pc_inc;
          end
        endcase
        state_d = ST_PUSH;
      end
      ST_PUSH: begin
        ram_we    = 1'b1;
        ram_addr  = sp_q;
        ram_wdata = ram_rdata;
        sp_d      = sp_dec;
        state_d   = ST_OUT;
      end
      ST_SWAP_RD: begin
        ram_re   = 1'b1;
        ram_addr = sp_inc2;
        state_d  = ST_SWAP_V;
      end
      ST_SWAP_V: begin
        v_d      = ram_rdata;
        ram_re   = 1'b1;
        ram_addr = sp_inc;
        state_d  = ST_SWAP_WR2;
      end
      ST_SWAP_WR2: begin
        ram_we    = 1'b1;
        ram_addr  = sp_inc2;
        ram_wdata = ram_rdata;
        state_d   = ST_SWAP_WR1;
      end
      ST_SWAP_WR1: begin
        ram_we    = 1'b1;
        ram_addr  = sp_inc;
        ram_wdata = v_q;
        state_d   = ST_OUT;
      end
      ST_IF_CHK: begin
        if (ram_rdata == 8'd0) begin
          ram_re   = 1'b1;
          ram_addr = pc_q;
          state_d  = ST_JMP_HI;
        end else begin
          pc_d    = pc_inc2;
          state_d = ST_OUT;
        end
      end
      ST_CALL_LO: begin
        ram_we    = 1'b1;
        ram_addr  = sp_q;
        ram_wdata = ret16[7:0];
        sp_d      = sp_dec;
        state_d   = ST_CALL_HI;
      end
      ST_CALL_HI: begin
        ram_we    = 1'b1;
        ram_addr  = sp_q;
        ram_wdata = ret16[15:8];
        sp_d      = sp_dec;
        state_d   = ST_CALL_RD;
      end
      ST_CALL_RD: begin
        ram_re   = 1'b1;
        ram_addr = pc_q;
        state_d  = ST_JMP_HI;
      end
      ST_JMP_HI: begin
        a_d      = ram_rdata;
        ram_re   = 1'b1;
        ram_addr = pc_inc;
        state_d  = ST_JMP_LO;
      end
      ST_JMP_LO: begin
        pc_d    = pair(a_q, ram_rdata);
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pc_q        <= '0;
      sp_q        <= '1;
      stopped_q   <= 1'b0;
      invalid_q   <= 1'b0;
      steps_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      sp_q        <= sp_d;
      stopped_q   <= stopped_d;
      invalid_q   <= invalid_d;
      steps_q     <= steps_d;
      out_valid_q <= out_load || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    v_q   <= v_d;
    opc_q <= opc_d;
    op_q  <= op_d;
    if (out_load) begin
      read_data_q   <= (op_q == bsm_pkg::OP_READ) ? ram_rdata : 8'd0;
      pc_out_q      <= 16'(pc_q);
      sp_out_q      <= 16'(sp_q);
      opcode_done_q <= opc_q;
      halted_q      <= stopped_q;
      bad_q         <= invalid_q;
      steps_out_q   <= steps_q;
    end
  end

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      stack_q <= '1;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        bsm_pkg::REG_START_ADDRESS: start_q <= pwdata[15:0];
        bsm_pkg::REG_STACK_START:   stack_q <= pwdata[15:0];
      endcase
    end
  end

  assign prdata = (paddr[2] == bsm_pkg::REG_STACK_START) ? {16'd0, stack_q}
                                                         : {16'd0, start_q};
  assign pready = 1'b1;

  assign out_valid_o           = out_valid_q;
  assign read_data_o           = read_data_q;
  assign program_counter_out_o = pc_out_q;
  assign stack_pointer_out_o   = sp_out_q;
  assign opcode_done_o         = opcode_done_q;
  assign halted_o              = halted_q;
  assign bad_opcode_o          = bad_q;
  assign steps_taken_o         = steps_out_q;

  a_no_idle_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && !in_acc) |-> !ram_we)
    else $error("RAM written while idle");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_OUT))
    else $error("result raised outside output state");

  a_step_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (steps_q != $past(steps_q)) |-> ($past(state_q) == ST_DECODE))
    else $error("step count changed outside decode");

  a_decode_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DECODE) |-> !stopped_q)
    else $error("instruction decoded while halted");

endmodule

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for byte_stack_machine_core. A scoreboard class keeps
// its own copy of memory, program counter, stack pointer, flags and step
// count, predicts one machine snapshot per request and compares every
// returned snapshot field by field. Instruction streams are built on the
// fly: before each step that the step task sends, the machine is dry-run,
// and any byte it would read that was never written is loaded first with a
// memory write, so programs run deep with no reads of unwritten memory.
// Sender bursts and receiver stall patterns are random.
// ----------------------------------------------------------------------------
typedef struct {
  logic [7:0]  read_data;
  logic [15:0] pc;
  logic [15:0] sp;
  logic [7:0]  opcode;
  logic        halted;
  logic        bad;
  logic [31:0] steps;
} machine_snapshot_t;

class bsm_scoreboard;
  logic [7:0]        mem [bsm_pkg::addr_t];
  bsm_pkg::addr_t    written_addrs [$];
  bsm_pkg::addr_t    pc;
  bsm_pkg::addr_t    sp;
  bit                stopped;
  bit                bad_seen;
  logic [31:0]       steps;
  bsm_pkg::addr_t    start_addr;
  bsm_pkg::addr_t    stack_base;
  machine_snapshot_t pending [$];

  // working copy for one instruction; dry mode keeps writes in scratch
  bit                dry;
  logic [7:0]        scratch [bsm_pkg::addr_t];
  bsm_pkg::addr_t    w_pc;
  bsm_pkg::addr_t    w_sp;
  bit                w_stop;
  bit                w_bad;
  logic [7:0]        fetched;
  bit                gap_found;
  bit                gap_is_opc;
  bsm_pkg::addr_t    gap_addr;
  int                n_reads;

  int errors;
  int n_checked;
  int n_requests;
  int n_ignored;
  int n_halts;
  int n_bad;
  int n_op [4];

  function new();
    pc         = '0;
    sp         = '1;
    stopped    = 1'b0;
    bad_seen   = 1'b0;
    steps      = '0;
    start_addr = '0;
    stack_base = '1;
    dry        = 1'b0;
  endfunction

  function logic [7:0] rd(bsm_pkg::addr_t a);
    logic [7:0] v;
    v = 8'h00;
    if (dry && scratch.exists(a)) v = scratch[a];
    else if (mem.exists(a)) v = mem[a];
    else if (!gap_found) begin
      gap_found  = 1'b1;
      gap_addr   = a;
      gap_is_opc = (n_reads == 0);
    end
    n_reads++;
    return v;
  endfunction

  function void wr(bsm_pkg::addr_t a, logic [7:0] v);
    if (dry) scratch[a] = v;
    else begin
      if (!mem.exists(a)) written_addrs.push_back(a);
      mem[a] = v;
    end
  endfunction

  function void push(logic [7:0] v);
    wr(w_sp, v);
    w_sp--;
  endfunction

  function logic [7:0] pop();
    w_sp++;
    return rd(w_sp);
  endfunction

  function void run_step();
    logic [7:0]     a;
    logic [7:0]     b;
    logic [7:0]     v;
    bsm_pkg::addr_t ret;
    w_pc      = pc;
    w_sp      = sp;
    w_stop    = 1'b0;
    w_bad     = bad_seen;
    gap_found = 1'b0;
    n_reads   = 0;
    scratch.delete();
    fetched = rd(w_pc);
    w_pc++;
    case (fetched)
      bsm_pkg::OPC_HALT:  w_stop = 1'b1;
      bsm_pkg::OPC_ADD:   begin a = pop(); b = pop(); push(a + b); end
      bsm_pkg::OPC_SUB:   begin a = pop(); b = pop(); push(a - b); end
      bsm_pkg::OPC_AND:   begin a = pop(); b = pop(); push(a & b); end
      bsm_pkg::OPC_OR:    begin a = pop(); b = pop(); push(a | b); end
      bsm_pkg::OPC_XOR:   begin a = pop(); b = pop(); push(a ^ b); end
      bsm_pkg::OPC_DROP:  a = pop();
      bsm_pkg::OPC_DUP:   push(rd(w_sp + 16'd1));
      bsm_pkg::OPC_OVER:  push(rd(w_sp + 16'd2));
      bsm_pkg::OPC_SWAP: begin
        v = rd(w_sp + 16'd2);
        wr(w_sp + 16'd2, rd(w_sp + 16'd1));
        wr(w_sp + 16'd1, v);
      end
      bsm_pkg::OPC_STORE: begin a = pop(); b = pop(); v = pop(); wr({a, b}, v); end
      bsm_pkg::OPC_FETCH: begin a = pop(); b = pop(); push(rd({a, b})); end
      bsm_pkg::OPC_LIT: begin
        v = rd(w_pc);
        w_pc++;
        push(v);
      end
      bsm_pkg::OPC_IF: begin
        if (pop() == 8'h00) begin
          a    = rd(w_pc);
          b    = rd(w_pc + 16'd1);
          w_pc = {a, b};
        end else begin
          w_pc += 16'd2;
        end
      end
      bsm_pkg::OPC_CALL: begin
        ret = w_pc + 16'd2;
        push(ret[7:0]);
        push(ret[15:8]);
        a    = rd(w_pc);
        b    = rd(w_pc + 16'd1);
        w_pc = {a, b};
      end
      bsm_pkg::OPC_EXIT:  begin a = pop(); b = pop(); w_pc = {a, b}; end
      default:            begin w_stop = 1'b1; w_bad = 1'b1; end
    endcase
  endfunction

  // true when the next step reads only bytes that hold written data
  function bit step_is_safe();
    dry = 1'b1;
    run_step();
    dry = 1'b0;
    return !gap_found;
  endfunction

  function void log_request(logic [1:0] op, bsm_pkg::addr_t addr, logic [7:0] data);
    machine_snapshot_t r;
    r.read_data = 8'h00;
    r.opcode    = 8'h00;
    n_requests++;
    n_op[op]++;
    case (op)
      bsm_pkg::OP_STEP: begin
        if (stopped) n_ignored++;
        else begin
          run_step();
          pc       = w_pc;
          sp       = w_sp;
          stopped  = w_stop;
          bad_seen = w_bad;
          steps++;
          r.opcode = fetched;
          if (w_bad) n_bad++;
          else if (w_stop) n_halts++;
        end
      end
      bsm_pkg::OP_WRITE: wr(addr, data);
      bsm_pkg::OP_READ:  r.read_data = mem.exists(addr) ? mem[addr] : 8'h00;
      bsm_pkg::OP_RESTART: begin
        pc       = start_addr;
        sp       = stack_base;
        stopped  = 1'b0;
        bad_seen = 1'b0;
      end
    endcase
    r.pc     = pc;
    r.sp     = sp;
    r.halted = stopped;
    r.bad    = bad_seen;
    r.steps  = steps;
    pending.push_back(r);
  endfunction

  function void cmp(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %h, got %h", $time, field, want, got);
    end
  endfunction

  function void check_result(machine_snapshot_t got);
    machine_snapshot_t want;
    if (pending.size() == 0) begin
      errors++;
      $display("%0t: unexpected result, pc %h sp %h opcode %h", $time, got.pc, got.sp,
               got.opcode);
      return;
    end
    want = pending.pop_front();
    n_checked++;
    cmp("read_data", want.read_data, got.read_data);
    cmp("program_counter", want.pc, got.pc);
    cmp("stack_pointer", want.sp, got.sp);
    cmp("opcode_done", want.opcode, got.opcode);
    cmp("halted", want.halted, got.halted);
    cmp("bad_opcode", want.bad, got.bad);
    cmp("steps_taken", want.steps, got.steps);
  endfunction
endclass

module tb;
  localparam int STALL_LIMIT = 3000;
  localparam int PHASE_ITEMS = 160;

  typedef enum logic [1:0] {STALL_NONE, STALL_COIN, STALL_LONG, STALL_ALTERNATE}
    stall_pattern_e;

  logic        clk_i                 = 1'b0;
  logic        rst_ni                = 1'b0;
  logic        in_valid_i            = 1'b0;
  logic        in_stall_o;
  logic [1:0]  op_i                  = bsm_pkg::OP_STEP;
  logic [15:0] address_i             = '0;
  logic [7:0]  data_i                = '0;
  logic        out_valid_o;
  logic        out_stall_i           = 1'b0;
  logic [7:0]  read_data_o;
  logic [15:0] program_counter_out_o;
  logic [15:0] stack_pointer_out_o;
  logic [7:0]  opcode_done_o;
  logic        halted_o;
  logic        bad_opcode_o;
  logic [31:0] steps_taken_o;
  logic        psel                  = 1'b0;
  logic        penable               = 1'b0;
  logic        pwrite                = 1'b0;
  logic [2:0]  paddr                 = '0;
  logic [31:0] pwdata                = '0;
  logic [31:0] prdata;
  logic        pready;

  bsm_scoreboard  sb = new();
  int             idle_cycles = 0;
  int             burst_left  = 0;
  stall_pattern_e stall_mode  = STALL_NONE;
  int             mode_left   = 0;
  int             hold_left   = 0;

  byte_stack_machine_core uut (.*);

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [7:0] pick_opcode();
    int         r;
    logic [7:0] v;
    r = $urandom_range(0, 99);
    if (r < 3) return bsm_pkg::OPC_HALT;
    if (r < 6) return 8'($urandom);
    case ($urandom_range(0, 14))
      0:       v = bsm_pkg::OPC_ADD;
      1:       v = bsm_pkg::OPC_SUB;
      2:       v = bsm_pkg::OPC_AND;
      3:       v = bsm_pkg::OPC_OR;
      4:       v = bsm_pkg::OPC_XOR;
      5:       v = bsm_pkg::OPC_DROP;
      6:       v = bsm_pkg::OPC_DUP;
      7:       v = bsm_pkg::OPC_OVER;
      8:       v = bsm_pkg::OPC_SWAP;
      9:       v = bsm_pkg::OPC_STORE;
      10:      v = bsm_pkg::OPC_FETCH;
      11:      v = bsm_pkg::OPC_LIT;
      12:      v = bsm_pkg::OPC_IF;
      13:      v = bsm_pkg::OPC_CALL;
      default: v = bsm_pkg::OPC_EXIT;
    endcase
    return v;
  endfunction

  // operand and stack bytes lean toward zero and all ones
  function automatic logic [7:0] fill_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return 8'h00;
    if (r < 30) return 8'hFF;
    return 8'($urandom);
  endfunction

  // all driver tasks start and end on a falling edge
  task automatic send(logic [1:0] op, bsm_pkg::addr_t addr, logic [7:0] data);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 99) < 40) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    op_i       <= op;
    address_i  <= addr;
    data_i     <= data;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    sb.log_request(op, addr, data);
    @(negedge clk_i);
  endtask

  task automatic step_op(int forced);
    while (!sb.stopped && !sb.step_is_safe()) begin
      if (sb.gap_is_opc)
        send(bsm_pkg::OP_WRITE, sb.gap_addr, (forced >= 0) ? 8'(forced) : pick_opcode());
      else
        send(bsm_pkg::OP_WRITE, sb.gap_addr, fill_byte());
    end
    send(bsm_pkg::OP_STEP, bsm_pkg::addr_t'($urandom), 8'($urandom));
  endtask

  task automatic write_config(logic sel, bsm_pkg::addr_t value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= 32'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (sel == bsm_pkg::REG_START_ADDRESS) sb.start_addr = value;
    else sb.stack_base = value;
    @(negedge clk_i);
  endtask

  task automatic wait_drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (sb.pending.size() != 0) @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    if (mode_left == 0) begin
      stall_mode <= stall_pattern_e'($urandom_range(0, 3));
      mode_left  <= $urandom_range(40, 200);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      STALL_NONE: out_stall_i <= 1'b0;
      STALL_COIN: out_stall_i <= 1'($urandom_range(0, 1));
      STALL_LONG: begin
        if (hold_left == 0) begin
          out_stall_i <= !out_stall_i;
          hold_left   <= out_stall_i ? $urandom_range(1, 3) : $urandom_range(1, 20);
        end else begin
          hold_left <= hold_left - 1;
        end
      end
      default: out_stall_i <= !out_stall_i;
    endcase
  end

  always @(posedge clk_i) begin
    machine_snapshot_t got;
    if (rst_ni) begin
      if (out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
        got = '{read_data_o, program_counter_out_o, stack_pointer_out_o, opcode_done_o,
                halted_o, bad_opcode_o, steps_taken_o};
        sb.check_result(got);
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel)
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("%0t: no handshake for %0d cycles, %0d results outstanding", $time,
             STALL_LIMIT, sb.pending.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    logic [7:0]     opcode_tour [$];
    bsm_pkg::addr_t cfg_start;
    bsm_pkg::addr_t cfg_stack;
    bsm_pkg::addr_t a;
    int             r;
    int             goal;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: extremes, illegal opcode, halted step, then steps that ask for every opcode
    write_config(bsm_pkg::REG_START_ADDRESS, 16'h0001);
    write_config(bsm_pkg::REG_STACK_START, 16'hFFFF);
    send(bsm_pkg::OP_WRITE, 16'hFFFF, 8'h00);
    send(bsm_pkg::OP_WRITE, 16'h0000, 8'hFF);
    send(bsm_pkg::OP_READ, 16'hFFFF, 8'h00);
    send(bsm_pkg::OP_READ, 16'h0000, 8'hFF);
    send(bsm_pkg::OP_STEP, 16'h0000, 8'h00);
    send(bsm_pkg::OP_STEP, 16'hFFFF, 8'hFF);
    send(bsm_pkg::OP_RESTART, 16'h5555, 8'hAA);
    opcode_tour = '{bsm_pkg::OPC_LIT, bsm_pkg::OPC_LIT, bsm_pkg::OPC_ADD, bsm_pkg::OPC_DUP,
                    bsm_pkg::OPC_OVER, bsm_pkg::OPC_SWAP, bsm_pkg::OPC_SUB,
                    bsm_pkg::OPC_AND, bsm_pkg::OPC_OR, bsm_pkg::OPC_XOR, bsm_pkg::OPC_DROP,
                    bsm_pkg::OPC_STORE, bsm_pkg::OPC_FETCH, bsm_pkg::OPC_CALL,
                    bsm_pkg::OPC_EXIT, bsm_pkg::OPC_IF, bsm_pkg::OPC_HALT};
    foreach (opcode_tour[i]) step_op(opcode_tour[i]);

    goal = sb.n_requests - sb.n_ignored;
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0:       begin cfg_start = 16'hFFFF; cfg_stack = 16'h0000; end
        1:       begin cfg_start = 16'h0000; cfg_stack = 16'hFFFF; end
        default: begin
          cfg_start = bsm_pkg::addr_t'($urandom);
          cfg_stack = bsm_pkg::addr_t'($urandom);
        end
      endcase
      wait_drain();
      write_config(bsm_pkg::REG_START_ADDRESS, cfg_start);
      write_config(bsm_pkg::REG_STACK_START, cfg_stack);
      send(bsm_pkg::OP_RESTART, bsm_pkg::addr_t'($urandom), 8'($urandom));
      goal += PHASE_ITEMS;
      while (sb.n_requests - sb.n_ignored < goal) begin
        r = $urandom_range(0, 99);
        if (sb.stopped) begin
          if (r < 75) send(bsm_pkg::OP_RESTART, bsm_pkg::addr_t'($urandom), 8'($urandom));
          else if (r < 90) send(bsm_pkg::OP_STEP, bsm_pkg::addr_t'($urandom), 8'($urandom));
          else send(bsm_pkg::OP_READ,
                    sb.written_addrs[$urandom_range(0, sb.written_addrs.size() - 1)],
                    8'($urandom));
        end else if (r < 72) begin
          step_op(-1);
        end else if (r < 80) begin
          send(bsm_pkg::OP_WRITE, bsm_pkg::addr_t'($urandom), fill_byte());
        end else if (r < 92) begin
          send(bsm_pkg::OP_READ,
               sb.written_addrs[$urandom_range(0, sb.written_addrs.size() - 1)],
               8'($urandom));
        end else if (r < 96) begin
          send(bsm_pkg::OP_RESTART, bsm_pkg::addr_t'($urandom), 8'($urandom));
        end else begin
          a = bsm_pkg::addr_t'($urandom);
          send(bsm_pkg::OP_WRITE, a, 8'($urandom));
          send(bsm_pkg::OP_READ, a, 8'($urandom));
        end
      end
    end

    wait_drain();
    repeat (20) @(negedge clk_i);
    $display("Ran %0d requests: %0d steps (%0d ignored while halted), %0d writes, %0d reads,",
             sb.n_requests, sb.n_op[bsm_pkg::OP_STEP], sb.n_ignored,
             sb.n_op[bsm_pkg::OP_WRITE], sb.n_op[bsm_pkg::OP_READ]);
    $display("%0d restarts over 6 register settings, %0d halts, %0d illegal opcodes, %0d checked",
             sb.n_op[bsm_pkg::OP_RESTART], sb.n_halts, sb.n_bad, sb.n_checked);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
rtl/bsm_pkg.sv
rtl/bsm_ram.sv
rtl/bsm_alu.sv
rtl/byte_stack_machine_core.sv
sim/tb.sv
